@@ src/mlpbp_pkg.sv @@
// Shared constants and elaboration-time helpers for the 2-2-1 backprop training block.
`timescale 1ns / 1ps

package mlpbp_pkg;

  localparam int SIG_DEPTH_DEF  = 1024;
  localparam int WFRAC_DEF      = 16;
  localparam int WEIGHT_W       = 32;
  localparam int ACT_W          = 16;
  localparam int LR_W           = 16;
  localparam logic [LR_W-1:0] LR_RESET = 16'd2048;
  // Pre-activation width seen by the sigmoid lookup.
  localparam int X_W            = 35;
  // Shared multiplier operand and product widths.
  localparam int MUL_A_W        = 34;
  localparam int MUL_B_W        = 18;
  localparam int PROD_W         = MUL_A_W + MUL_B_W;

  // e^-n in Q30 for n = 0..8.
  localparam logic [31:0] EXP_NEG_INT [9] = '{
    32'd1073741824, 32'd395007542, 32'd145315154, 32'd53458458, 32'd19666267,
    32'd7234817, 32'd2661540, 32'd979126, 32'd360200
  };

  // Restoring unsigned divide, used only while building the sigmoid table.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid at the center of bin k of a depth-entry table over [-8,8).
  function automatic logic [ACT_W-1:0] sig_entry(input int k, input int depth);
    logic [63:0] num0;
    longint      xq;
    logic [63:0] u;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] t;
    longint      sum;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] r;
    num0 = 64'(8 * (2 * k + 1)) << 30;
    xq   = longint'(udiv64(num0, 64'(depth))) - (longint'(8) << 30);
    u    = (xq < 0) ? 64'(-xq) : 64'(xq);
    n    = u >> 30;
    if (n > 64'd8) begin
      n = 64'd8;
    end
    f   = u & ((64'd1 << 30) - 64'd1);
    sum = longint'(1) << 30;
    t   = 64'd1 << 30;
    for (int j = 1; j <= 16; j++) begin
      t = udiv64((t * f) >> 30, 64'(j));
      if ((j % 2) == 1) begin
        sum = sum - longint'(t);
      end else begin
        sum = sum + longint'(t);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e   = (64'(sum) * 64'(EXP_NEG_INT[n[3:0]])) >> 30;
    num = (xq < 0) ? e : (64'd1 << 30);
    den = (64'd1 << 30) + e;
    r   = udiv64((num << 17) + den, den << 1);
    if (r > 64'd65535) begin
      r = 64'd65535;
    end
    return r[ACT_W-1:0];
  endfunction

  // Saturating weight add: bit 32 flags a clamp, bits 31:0 hold the weight.
  function automatic logic [WEIGHT_W:0] sat_add(input logic signed [WEIGHT_W-1:0] w,
                                                input logic signed [PROD_W-1:0] d);
    logic signed [PROD_W:0] s;
    s = (PROD_W+1)'(w) + (PROD_W+1)'(d);
    if (s > (PROD_W+1)'(signed'(32'sh7fffffff))) begin
      return {1'b1, 32'h7fffffff};
    end else if (s < (PROD_W+1)'(signed'(32'sh80000000))) begin
      return {1'b1, 32'h80000000};
    end
    return {1'b0, s[WEIGHT_W-1:0]};
  endfunction

endpackage

@@ src/mlp_2_2_1_backprop_train_step.sv @@
// Top level: 2-2-1 sigmoid network with forward pass and online backprop update.
`timescale 1ns / 1ps

// Each request takes two binary inputs, runs the forward pass over six Q16.16
// weights and returns the output sigmoid, its class bit and a clamp flag. A
// train request (cmd = 1) then updates both output weights and the hidden
// weights of the inputs that are 1, in place. One signed 34x18 multiplier is
// shared under a one-hot sequencer. out_valid rises after an infer request
// runs the forward pass, and after a train request runs the update as well.
// The three table lookups and the chain of dependent multiplies set the length
// of a request. A new request is taken once the sequencer is back in idle,
// even while a result still waits.
module mlp_2_2_1_backprop_train_step #(
  parameter int SIGMOID_TABLE_DEPTH = mlpbp_pkg::SIG_DEPTH_DEF,
  parameter int WEIGHT_FRAC_BITS    = mlpbp_pkg::WFRAC_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic                               in_in_a,
  input  logic                               in_in_b,
  input  logic                               in_target,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mlpbp_pkg::ACT_W-1:0]        out_activation,
  output logic                               out_class_bit,
  output logic                               out_saturated,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mlpbp_pkg::LR_W-1:0]         cfg_data
);

  localparam int AW = mlpbp_pkg::MUL_A_W;
  localparam int BW = mlpbp_pkg::MUL_B_W;
  localparam int PW = mlpbp_pkg::PROD_W;
  localparam int XW = mlpbp_pkg::X_W;
  localparam int WW = mlpbp_pkg::WEIGHT_W;
  localparam int DW2_SHIFT = 44 - WEIGHT_FRAC_BITS;
  localparam logic signed [WW-1:0] HALF = WW'(1) <<< (WEIGHT_FRAC_BITS - 1);

  typedef enum logic [21:0] {
    ST_IDLE = 22'h000001,
    ST_Z0   = 22'h000002,
    ST_I0   = 22'h000004,
    ST_H0   = 22'h000008,
    ST_I1   = 22'h000010,
    ST_H1   = 22'h000020,
    ST_M0   = 22'h000040,
    ST_M1   = 22'h000080,
    ST_Y    = 22'h000100,
    ST_I2   = 22'h000200,
    ST_O    = 22'h000400,
    ST_SO   = 22'h000800,
    ST_ER   = 22'h001000,
    ST_DO   = 22'h002000,
    ST_Q    = 22'h004000,
    ST_SH   = 22'h008000,
    ST_DH   = 22'h010000,
    ST_LD   = 22'h020000,
    ST_W2M  = 22'h040000,
    ST_W2   = 22'h080000,
    ST_W1   = 22'h100000,
    ST_FIN  = 22'h200000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [mlpbp_pkg::LR_W-1:0] lr_r;
  logic signed [WW-1:0]      hw_r [4];
  logic signed [WW-1:0]      ow_r [2];
  logic                      cmd_r, a_r, b_r, tgt_r;
  logic                      i_r;
  logic                      sat_r;
  logic signed [XW-1:0]      x_r;
  logic [15:0]               h0_r, h1_r, o_r;
  logic signed [PW-1:0]      prod_r;
  logic signed [PW-1:0]      acc_r;
  logic signed [BW-1:0]      dout_r;
  logic signed [AW-1:0]      q_r;
  logic signed [AW-1:0]      dh_r;
  logic                      out_valid_r;
  logic [15:0]               out_act_r;
  logic                      out_sat_r;

  logic signed [AW-1:0]      mul_a;
  logic signed [BW-1:0]      mul_b;
  logic signed [PW-1:0]      prod_nxt;
  logic [15:0]               sig_y;
  logic                      idx_load;
  logic signed [XW-1:0]      z_sel;
  logic signed [WW-1:0]      ow_i, hw_lo, hw_hi;
  logic [15:0]               h_i;
  logic signed [PW-1:0]      dw2, dw1;
  logic [WW:0]               ow_upd, hwl_upd, hwh_upd;
  logic                      take_out;

  mlpbp_sigmoid #(
    .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH),
    .WEIGHT_FRAC_BITS    (WEIGHT_FRAC_BITS)
  ) u_sig (
    .clk      (clk),
    .idx_load (idx_load),
    .x        (x_r),
    .sig_y    (sig_y)
  );

  // Per-unit operand selection.
  assign ow_i  = i_r ? ow_r[1] : ow_r[0];
  assign hw_lo = i_r ? hw_r[1] : hw_r[0];
  assign hw_hi = i_r ? hw_r[3] : hw_r[2];
  assign h_i   = i_r ? h1_r : h0_r;

  // Hidden pre-activation of the unit picked by i_r.
  always_comb begin
    z_sel = '0;
    if (a_r) begin
      z_sel = z_sel + XW'(hw_lo);
    end
    if (b_r) begin
      z_sel = z_sel + XW'(hw_hi);
    end
  end

  assign idx_load = (state_r == ST_I0) || (state_r == ST_I1) || (state_r == ST_I2);

  // Route operands to the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_M0: begin
        mul_a = AW'(ow_r[0]);
        mul_b = BW'({1'b0, h0_r});
      end
      ST_M1: begin
        mul_a = AW'(ow_r[1]);
        mul_b = BW'({1'b0, h1_r});
      end
      ST_SO: begin
        mul_a = AW'(18'sd65536 - BW'({1'b0, o_r}));
        mul_b = BW'({1'b0, o_r});
      end
      ST_ER: begin
        mul_a = AW'({1'b0, prod_r[31:16]});
        mul_b = (tgt_r ? 18'sd65536 : 18'sd0) - BW'({1'b0, o_r});
      end
      ST_Q: begin
        mul_a = AW'(ow_i);
        mul_b = dout_r;
      end
      ST_SH: begin
        mul_a = AW'(18'sd65536 - BW'({1'b0, h_i}));
        mul_b = BW'({1'b0, h_i});
      end
      ST_DH: begin
        mul_a = q_r;
        mul_b = BW'({1'b0, prod_r[31:16]});
      end
      ST_LD: begin
        mul_a = AW'(dout_r);
        mul_b = BW'({1'b0, lr_r});
      end
      ST_W2M: begin
        mul_a = prod_r[AW-1:0];
        mul_b = BW'({1'b0, h_i});
      end
      ST_W2: begin
        mul_a = dh_r;
        mul_b = BW'({1'b0, lr_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = PW'(mul_a) * PW'(mul_b);

  // Weight deltas and clamped updates.
  assign dw2     = prod_r >>> DW2_SHIFT;
  assign dw1     = prod_r >>> 12;
  assign ow_upd  = mlpbp_pkg::sat_add(ow_i, dw2);
  assign hwl_upd = mlpbp_pkg::sat_add(hw_lo, dw1);
  assign hwh_upd = mlpbp_pkg::sat_add(hw_hi, dw1);

  assign take_out = !out_valid_r || !out_stall;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_Z0;
      ST_Z0:   state_nxt = ST_I0;
      ST_I0:   state_nxt = ST_H0;
      ST_H0:   state_nxt = ST_I1;
      ST_I1:   state_nxt = ST_H1;
      ST_H1:   state_nxt = ST_M0;
      ST_M0:   state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_Y;
      ST_Y:    state_nxt = ST_I2;
      ST_I2:   state_nxt = ST_O;
      ST_O:    state_nxt = cmd_r ? ST_SO : ST_FIN;
      ST_SO:   state_nxt = ST_ER;
      ST_ER:   state_nxt = ST_DO;
      ST_DO:   state_nxt = ST_Q;
      ST_Q:    state_nxt = ST_SH;
      ST_SH:   state_nxt = ST_DH;
      ST_DH:   state_nxt = ST_LD;
      ST_LD:   state_nxt = ST_W2M;
      ST_W2M:  state_nxt = ST_W2;
      ST_W2:   state_nxt = ST_W1;
      ST_W1:   state_nxt = i_r ? ST_FIN : ST_Q;
      ST_FIN:  if (take_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, weights and the learning-rate register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lr_r        <= mlpbp_pkg::LR_RESET;
      hw_r[0]     <= HALF;
      hw_r[1]     <= -HALF;
      hw_r[2]     <= -HALF;
      hw_r[3]     <= HALF;
      ow_r[0]     <= HALF;
      ow_r[1]     <= HALF;
      out_valid_r <= 1'b0;
      i_r         <= 1'b0;
      sat_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        lr_r <= cfg_data;
      end
      // Raise on a finished request, hold while stalled, drop once taken.
      out_valid_r <= ((state_r == ST_FIN) && take_out) || (out_valid_r && out_stall);
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            i_r   <= 1'b0;
            sat_r <= 1'b0;
          end
        end
        ST_I0: i_r <= 1'b1;
        ST_H1: i_r <= 1'b0;
        ST_W2: begin
          if (i_r) begin
            ow_r[1] <= ow_upd[WW-1:0];
          end else begin
            ow_r[0] <= ow_upd[WW-1:0];
          end
          sat_r <= sat_r | ow_upd[WW];
        end
        ST_W1: begin
          if (a_r) begin
            if (i_r) begin
              hw_r[1] <= hwl_upd[WW-1:0];
            end else begin
              hw_r[0] <= hwl_upd[WW-1:0];
            end
          end
          if (b_r) begin
            if (i_r) begin
              hw_r[3] <= hwh_upd[WW-1:0];
            end else begin
              hw_r[2] <= hwh_upd[WW-1:0];
            end
          end
          sat_r <= sat_r | (a_r & hwl_upd[WW]) | (b_r & hwh_upd[WW]);
          i_r   <= ~i_r;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_r <= in_cmd;
          a_r   <= in_in_a;
          b_r   <= in_in_b;
          tgt_r <= in_target;
        end
      end
      ST_Z0:  x_r <= z_sel;
      ST_H0: begin
        h0_r <= sig_y;
        x_r  <= z_sel;
      end
      ST_H1:  h1_r  <= sig_y;
      ST_M1:  acc_r <= prod_r;
      ST_Y:   x_r   <= XW'((acc_r + prod_r) >>> 16);
      ST_O:   o_r   <= sig_y;
      ST_DO:  dout_r <= BW'(prod_r >>> 16);
      ST_SH:  q_r   <= AW'(prod_r >>> 16);
      ST_LD:  dh_r  <= AW'(prod_r >>> 16);
      ST_FIN: begin
        if (take_out) begin
          out_act_r <= o_r;
          out_sat_r <= sat_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_activation = out_act_r;
  assign out_class_bit  = (out_act_r > 16'd32768);
  assign out_saturated  = out_sat_r;

endmodule

@@ src/mlpbp_sigmoid.sv @@
// Sigmoid lookup: registered table index from a fixed-point pre-activation, then table read.
`timescale 1ns / 1ps

module mlpbp_sigmoid #(
  parameter int SIGMOID_TABLE_DEPTH = mlpbp_pkg::SIG_DEPTH_DEF,
  parameter int WEIGHT_FRAC_BITS    = mlpbp_pkg::WFRAC_DEF
) (
  input  logic                                clk,
  input  logic                                idx_load,
  input  logic signed [mlpbp_pkg::X_W-1:0]    x,
  output logic        [mlpbp_pkg::ACT_W-1:0]  sig_y
);

  localparam int IW = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int FW = WEIGHT_FRAC_BITS + 4;
  localparam int PW = FW + IW + 1;

  logic        [mlpbp_pkg::ACT_W-1:0] tbl [SIGMOID_TABLE_DEPTH];
  logic signed [mlpbp_pkg::X_W:0]     xs;
  logic        [PW-1:0]               scaled;
  logic        [IW-1:0]               idx_nxt;
  logic        [IW-1:0]               idx_r;

  // Build the constant table at elaboration.
  for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_tbl
    localparam logic [mlpbp_pkg::ACT_W-1:0] ENTRY =
      mlpbp_pkg::sig_entry(g, SIGMOID_TABLE_DEPTH);
    assign tbl[g] = ENTRY;
  end

  // Shift into [0,16), clamp outside, scale to a bin number.
  always_comb begin
    xs     = (mlpbp_pkg::X_W+1)'(x) + ((mlpbp_pkg::X_W+1)'(8) <<< WEIGHT_FRAC_BITS);
    scaled = PW'(xs[FW-1:0]) * PW'(SIGMOID_TABLE_DEPTH);
    if (xs < 0) begin
      idx_nxt = '0;
    end else if (xs >= ((mlpbp_pkg::X_W+1)'(16) <<< WEIGHT_FRAC_BITS)) begin
      idx_nxt = IW'(SIGMOID_TABLE_DEPTH - 1);
    end else begin
      idx_nxt = scaled[FW +: IW];
    end
  end

  always_ff @(posedge clk) begin
    if (idx_load) begin
      idx_r <= idx_nxt;
    end
  end

  assign sig_y = tbl[idx_r];

endmodule
